FILE: src/drvi_pkg.sv
package drvi_pkg;

	// Field widths fixed by the interface.
	localparam int TIME_W = 32;
	localparam int DATA_W = 32;
	localparam int POS_W  = 48;
	localparam int FUNC_W = 3;

	// Wide working width for products and sums ahead of saturation.
	localparam int WIDE_W = 66;

	// Elapsed-time conversion: divide by 1000 as (x >> 3) / 125 via a reciprocal.
	localparam int                  MS_PER_S     = 1000;
	localparam int                  MS_HALF      = 500;
	localparam int                  DIV125       = 125;
	localparam logic [29:0]         RECIP125     = 30'd549755813;  // floor(2^36 / 125)
	localparam int                  RECIP_SHIFT  = 36;
	localparam int                  RECIP_W      = 30;
	localparam int                  QD_W         = 23;             // width of (2^32-1) / 1000
	localparam int                  RD_W         = 10;             // remainder below 1000
	localparam int                  DT_W         = 31;
	localparam logic [DT_W-1:0]     DT_MAX       = '1;

	// Radians to degrees, scaled: round(57.29577951 * 2^FRAC_BITS).
	localparam longint unsigned     R2D_SCALED   = 64'd5729577951;
	localparam longint unsigned     R2D_DIV      = 64'd100000000;

	// Item function codes.
	typedef enum logic [FUNC_W-1:0] {
		FN_SAMPLE  = 3'd0,
		FN_CLR_POS = 3'd1,
		FN_CLR_VEL = 3'd2,
		FN_CLR_YAW = 3'd3,
		FN_CLR_ALL = 3'd4
	} func_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DT,
		ST_LANE,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [FUNC_W-1:0]        func;
		logic [TIME_W-1:0]        read_time_ms;
		logic signed [DATA_W-1:0] accel_x;
		logic signed [DATA_W-1:0] accel_y;
		logic signed [DATA_W-1:0] gyro_z;
	} sample_t;

	typedef struct packed {
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic signed [DATA_W-1:0] vel_x;
		logic signed [DATA_W-1:0] vel_y;
		logic signed [DATA_W-1:0] yaw_deg;
	} result_t;

	// Commands from the sequencer to the lanes.
	typedef struct packed {
		logic start;
		logic clr_pos;
		logic clr_vel;
		logic clr_yaw;
	} lane_ctl_t;

	// Arithmetic shift right by n that rounds half up.
	function automatic logic signed [WIDE_W-1:0] rnd_shr(
		input logic signed [WIDE_W-1:0] x,
		input int                       n
	);
		logic signed [WIDE_W-1:0] half;
		half = WIDE_W'(1) <<< (n - 1);
		return (x + half) >>> n;
	endfunction

	// Saturate to a signed 32-bit value.
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = WIDE_W'(32'sh7fffffff);
		lo = -hi - WIDE_W'(1);
		if (x > hi) begin
			return {1'b0, {(DATA_W-1){1'b1}}};
		end else if (x < lo) begin
			return {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			return x[DATA_W-1:0];
		end
	endfunction

	// Saturate to the signed position width.
	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [WIDE_W-1:0] x);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = WIDE_W'({1'b0, {(POS_W-1){1'b1}}});
		lo = -hi - WIDE_W'(1);
		if (x > hi) begin
			return {1'b0, {(POS_W-1){1'b1}}};
		end else if (x < lo) begin
			return {1'b1, {(POS_W-1){1'b0}}};
		end else begin
			return x[POS_W-1:0];
		end
	endfunction

endpackage

FILE: src/dead_reckoning_verlet_integrator.sv
// Channel   Direction  Handshake                     Payload
// sample    in         sample_valid / sample_stall   drvi_pkg::sample_t
// result    out        result_valid / result_stall   drvi_pkg::result_t
//
// A sample item holds the input while it passes the divide-by-1000 pipeline that
// turns milliseconds into seconds and the lanes (two multiplier stages each), while
// the sequencer hands over to the output stage, and until the result register is loaded,
// which makes its result valid. A clear item, or an unused function code, goes straight
// to that hand-over state and holds the input until the result register is loaded.
// Reset clears all integrator state and the sequencer; the block is ready at once.
// A stalled result holds its register; the next item may already be in work.
module dead_reckoning_verlet_integrator #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  drvi_pkg::sample_t    sample,
	output logic                 result_valid,
	input  logic                 result_stall,
	output drvi_pkg::result_t    result
);

	drvi_pkg::state_t                    state_q, state_d;
	drvi_pkg::lane_ctl_t                 ctl;
	drvi_pkg::result_t                   result_q;
	logic                                result_valid_q;
	logic                                accept;
	logic                                dt_start;
	logic                                dt_done;
	logic                                res_load;
	logic                                lanes_done;
	logic                                done_x, done_y, done_yaw;
	logic [drvi_pkg::DT_W-1:0]           dt;
	logic [drvi_pkg::TIME_W-1:0]         last_time_q;
	logic signed [drvi_pkg::DATA_W-1:0]  ax_q, ay_q, gz_q;
	logic signed [drvi_pkg::DATA_W-1:0]  vel_x, vel_y, yaw;
	logic signed [drvi_pkg::POS_W-1:0]   pos_x, pos_y;

	assign sample_stall = (state_q != drvi_pkg::ST_IDLE);
	assign accept       = sample_valid && !sample_stall;
	assign lanes_done   = done_x && done_y && done_yaw;

	// Sequencer: next state and command strobes.
	always_comb begin
		state_d     = state_q;
		dt_start    = 1'b0;
		res_load    = 1'b0;
		ctl         = '0;
		unique case (state_q)
			drvi_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = drvi_pkg::ST_FIN;
					unique case (sample.func)
						drvi_pkg::FN_SAMPLE: begin
							dt_start = 1'b1;
							state_d  = drvi_pkg::ST_DT;
						end
						drvi_pkg::FN_CLR_POS: ctl.clr_pos = 1'b1;
						drvi_pkg::FN_CLR_VEL: ctl.clr_vel = 1'b1;
						drvi_pkg::FN_CLR_YAW: ctl.clr_yaw = 1'b1;
						drvi_pkg::FN_CLR_ALL: begin
							ctl.clr_pos = 1'b1;
							ctl.clr_vel = 1'b1;
							ctl.clr_yaw = 1'b1;
						end
						default: ;
					endcase
				end
			end
			drvi_pkg::ST_DT: begin
				if (dt_done) begin
					ctl.start = 1'b1;
					state_d   = drvi_pkg::ST_LANE;
				end
			end
			drvi_pkg::ST_LANE: begin
				if (lanes_done) begin
					state_d = drvi_pkg::ST_FIN;
				end
			end
			drvi_pkg::ST_FIN: begin
				if (!result_valid_q || !result_stall) begin
					res_load = 1'b1;
					state_d  = drvi_pkg::ST_IDLE;
				end
			end
			default: state_d = drvi_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= drvi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Timestamp of the previous sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
		end else if (dt_start) begin
			last_time_q <= sample.read_time_ms;
		end
	end

	// New sample values held while the lanes work.
	always_ff @(posedge clk) begin
		if (dt_start) begin
			ax_q <= sample.accel_x;
			ay_q <= sample.accel_y;
			gz_q <= sample.gyro_z;
		end
	end

	drvi_dt #(.FRAC_BITS(FRAC_BITS)) u_dt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dt_start),
		.dms    (sample.read_time_ms - last_time_q),
		.done   (dt_done),
		.dt     (dt)
	);

	drvi_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.dt     (dt),
		.accel  (ax_q),
		.done   (done_x),
		.vel    (vel_x),
		.pos    (pos_x)
	);

	drvi_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.dt     (dt),
		.accel  (ay_q),
		.done   (done_y),
		.vel    (vel_y),
		.pos    (pos_y)
	);

	drvi_yaw #(.FRAC_BITS(FRAC_BITS)) u_yaw (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.dt     (dt),
		.gyro   (gz_q),
		.done   (done_yaw),
		.yaw    (yaw)
	);

	// Merge the lane states into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			result_q.pos_x   <= pos_x;
			result_q.pos_y   <= pos_y;
			result_q.vel_x   <= vel_x;
			result_q.vel_y   <= vel_y;
			result_q.yaw_deg <= yaw;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

FILE: src/drvi_dt.sv
module drvi_dt #(
	parameter int FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [drvi_pkg::TIME_W-1:0]    dms,
	output logic                           done,
	output logic [drvi_pkg::DT_W-1:0]      dt
);

	// Widths of the second (remainder) division, the first division and the full result.
	localparam int NUM_W = drvi_pkg::RD_W + FRAC_BITS;
	localparam int Z_W   = NUM_W - 3;
	localparam int P2_W  = Z_W + drvi_pkg::RECIP_W;
	localparam int Q1_W  = P2_W - drvi_pkg::RECIP_SHIFT;
	localparam int P1_W  = drvi_pkg::TIME_W - 3 + drvi_pkg::RECIP_W;
	localparam int DW    = drvi_pkg::QD_W + FRAC_BITS + 1;
	localparam int R0_W  = drvi_pkg::TIME_W + 1;

	logic                          v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [drvi_pkg::TIME_W-1:0]   d_s1, d_s2;
	logic [P1_W-1:0]               prod_s2;
	logic [drvi_pkg::QD_W-1:0]     qd_s3, qd_s4;
	logic [drvi_pkg::RD_W-1:0]     rd_s3;
	logic [P2_W-1:0]               prod_s4;
	logic [Z_W-1:0]                z_s4;
	logic [drvi_pkg::DT_W-1:0]     dt_s5;

	logic [drvi_pkg::QD_W-1:0]     q0;
	logic [R0_W-1:0]               rem0;
	logic [NUM_W-1:0]              num;
	logic [Z_W-1:0]                z;
	logic [Q1_W-1:0]               q1;
	logic [Q1_W-1:0]               q1c;
	logic [Z_W-1:0]                rem1;
	logic [DW-1:0]                 dt_full;

	// Stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// First quotient estimate and its correction: dms = 1000 * qd + rd.
	always_comb begin
		q0   = prod_s2[P1_W-1 -: drvi_pkg::QD_W];
		rem0 = R0_W'(d_s2) - R0_W'(q0) * R0_W'(drvi_pkg::MS_PER_S);
	end

	// Remainder scaled to seconds: (rd * 2^F + 500) / 1000 = ((...) >> 3) / 125.
	always_comb begin
		num  = (NUM_W'(rd_s3) << FRAC_BITS) + NUM_W'(drvi_pkg::MS_HALF);
		z    = num[NUM_W-1:3];
		q1   = prod_s4[P2_W-1 -: Q1_W];
		rem1 = z_s4 - Z_W'(q1) * Z_W'(drvi_pkg::DIV125);
		q1c  = (rem1 >= Z_W'(drvi_pkg::DIV125)) ? q1 + Q1_W'(1) : q1;
		dt_full = (DW'(qd_s4) << FRAC_BITS) + DW'(q1c);
	end

	// Datapath stages.
	always_ff @(posedge clk) begin
		if (start) begin
			d_s1 <= dms;
		end
		if (v_s1) begin
			d_s2    <= d_s1;
			prod_s2 <= P1_W'(d_s1[drvi_pkg::TIME_W-1:3]) * P1_W'(drvi_pkg::RECIP125);
		end
		if (v_s2) begin
			if (rem0 >= R0_W'(drvi_pkg::MS_PER_S)) begin
				qd_s3 <= q0 + drvi_pkg::QD_W'(1);
				rd_s3 <= drvi_pkg::RD_W'(rem0 - R0_W'(drvi_pkg::MS_PER_S));
			end else begin
				qd_s3 <= q0;
				rd_s3 <= drvi_pkg::RD_W'(rem0);
			end
		end
		if (v_s3) begin
			qd_s4   <= qd_s3;
			z_s4    <= z;
			prod_s4 <= P2_W'(z) * P2_W'(drvi_pkg::RECIP125);
		end
		if (v_s4) begin
			dt_s5 <= (dt_full > DW'(drvi_pkg::DT_MAX)) ? drvi_pkg::DT_MAX
				: dt_full[drvi_pkg::DT_W-1:0];
		end
	end

	assign done = v_s5;
	assign dt   = dt_s5;

endmodule

FILE: src/drvi_axis.sv
module drvi_axis #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  drvi_pkg::lane_ctl_t                   ctl,
	input  logic [drvi_pkg::DT_W-1:0]             dt,
	input  logic signed [drvi_pkg::DATA_W-1:0]    accel,
	output logic                                  done,
	output logic signed [drvi_pkg::DATA_W-1:0]    vel,
	output logic signed [drvi_pkg::POS_W-1:0]     pos
);

	localparam int WW = drvi_pkg::WIDE_W;

	logic                                v_s1, v_s2, v_s3, v_s4;
	logic signed [WW-1:0]                p_old_s1, p_sum_s1, p_pos_s3;
	logic signed [drvi_pkg::DATA_W-1:0]  h_s2, vnew_s2, vnew_s3;
	logic signed [drvi_pkg::DATA_W-1:0]  acc_q, vel_q;
	logic signed [drvi_pkg::POS_W-1:0]   pos_q;
	logic signed [WW-1:0]                dt_w;
	logic signed [WW-1:0]                acc_sum;
	logic signed [WW-1:0]                h_next, v_next, p_next;

	// Stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= ctl.start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Half-step velocity, new velocity and the new position.
	always_comb begin
		dt_w    = WW'($signed({1'b0, dt}));
		acc_sum = WW'(acc_q) + WW'(accel);
		h_next  = WW'(vel_q) + drvi_pkg::rnd_shr(p_old_s1, FRAC_BITS + 1);
		v_next  = WW'(vel_q) + drvi_pkg::rnd_shr(p_sum_s1, FRAC_BITS + 1);
		p_next  = WW'(pos_q) + drvi_pkg::rnd_shr(p_pos_s3, FRAC_BITS);
	end

	// Datapath stages.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			p_old_s1 <= WW'(acc_q) * dt_w;
			p_sum_s1 <= acc_sum * dt_w;
		end
		if (v_s1) begin
			h_s2    <= drvi_pkg::sat32(h_next);
			vnew_s2 <= drvi_pkg::sat32(v_next);
		end
		if (v_s2) begin
			p_pos_s3 <= WW'(h_s2) * dt_w;
			vnew_s3  <= vnew_s2;
		end
	end

	// Lane state: commit after the last stage, or clear on command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			vel_q <= '0;
			pos_q <= '0;
		end else if (v_s3) begin
			acc_q <= accel;
			vel_q <= vnew_s3;
			pos_q <= drvi_pkg::sat_pos(p_next);
		end else begin
			if (ctl.clr_pos) begin
				pos_q <= '0;
			end
			if (ctl.clr_vel) begin
				vel_q <= '0;
			end
		end
	end

	assign done = v_s4;
	assign vel  = vel_q;
	assign pos  = pos_q;

endmodule

FILE: src/drvi_yaw.sv
module drvi_yaw #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  drvi_pkg::lane_ctl_t                   ctl,
	input  logic [drvi_pkg::DT_W-1:0]             dt,
	input  logic signed [drvi_pkg::DATA_W-1:0]    gyro,
	output logic                                  done,
	output logic signed [drvi_pkg::DATA_W-1:0]    yaw
);

	localparam int WW = drvi_pkg::WIDE_W;
	localparam longint unsigned RAD2DEG_U =
		((drvi_pkg::R2D_SCALED << FRAC_BITS) + (drvi_pkg::R2D_DIV >> 1)) / drvi_pkg::R2D_DIV;
	localparam logic signed [drvi_pkg::DATA_W-1:0] RAD2DEG = drvi_pkg::DATA_W'(RAD2DEG_U);

	logic                                v_s1, v_s2, v_s3, v_s4;
	logic signed [WW-1:0]                pg_s1, pm_s3;
	logic signed [drvi_pkg::DATA_W-1:0]  r_s2;
	logic signed [drvi_pkg::DATA_W-1:0]  yaw_q;
	logic signed [WW-1:0]                y_next;

	// Stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= ctl.start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign y_next = WW'(yaw_q) + drvi_pkg::rnd_shr(pm_s3, FRAC_BITS);

	// Angle step in radians, then scaled to degrees.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			pg_s1 <= WW'(gyro) * WW'($signed({1'b0, dt}));
		end
		if (v_s1) begin
			r_s2 <= drvi_pkg::sat32(drvi_pkg::rnd_shr(pg_s1, FRAC_BITS));
		end
		if (v_s2) begin
			pm_s3 <= WW'(r_s2) * WW'(RAD2DEG);
		end
	end

	// Accumulated yaw.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_q <= '0;
		end else if (v_s3) begin
			yaw_q <= drvi_pkg::sat32(y_next);
		end else if (ctl.clr_yaw) begin
			yaw_q <= '0;
		end
	end

	assign done = v_s4;
	assign yaw  = yaw_q;

endmodule

FILE: verif/dead_reckoning_checker.sv
module dead_reckoning_checker #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	input  logic              sample_stall,
	input  drvi_pkg::sample_t sample,
	input  logic              result_valid,
	input  logic              result_stall,
	input  drvi_pkg::result_t result,
	output int                mismatches,
	output int                pending,
	output int                checked
);
	timeunit 1ns;
	timeprecision 1ps;

	// Working width for products and sums; wide enough that nothing wraps.
	typedef logic signed [71:0] wide_t;

	localparam wide_t Q31_MAX = 72'sd2147483647;
	localparam wide_t Q31_MIN = -72'sd2147483648;
	localparam wide_t POS_MAX = (wide_t'(1) <<< (drvi_pkg::POS_W - 1)) - wide_t'(1);
	localparam wide_t POS_MIN = -POS_MAX - wide_t'(1);

	// Milliseconds to seconds, rounded to nearest, capped at the largest step.
	localparam longint unsigned MSEC_PER_SEC = 1000;
	localparam longint unsigned HALF_MSEC    = 500;
	localparam longint unsigned DT_CEILING   = 64'h7FFF_FFFF;

	// Degrees per radian, carried with eight decimals, then scaled to the fraction.
	localparam longint unsigned DEG_PER_RAD_E8 = 64'd5729577951;
	localparam longint unsigned SCALE_E8       = 64'd100000000;
	localparam wide_t RAD_TO_DEG =
		wide_t'(((DEG_PER_RAD_E8 << FRAC_BITS) + SCALE_E8 / 2) / SCALE_E8);

	// Navigation state as the block should hold it.
	logic signed [drvi_pkg::DATA_W-1:0] prev_accel_x;
	logic signed [drvi_pkg::DATA_W-1:0] prev_accel_y;
	logic signed [drvi_pkg::DATA_W-1:0] vel_x;
	logic signed [drvi_pkg::DATA_W-1:0] vel_y;
	logic signed [drvi_pkg::DATA_W-1:0] yaw;
	logic signed [drvi_pkg::POS_W-1:0]  pos_x;
	logic signed [drvi_pkg::POS_W-1:0]  pos_y;
	logic [drvi_pkg::TIME_W-1:0]        prev_time_ms;

	// Fixes predicted for accepted items, oldest first.
	drvi_pkg::result_t expected_fixes[$];
	drvi_pkg::result_t oldest;

	// Arithmetic shift right that rounds half up.
	function automatic wide_t round_shift(input wide_t x, input int n);
		wide_t half;
		half = wide_t'(1) <<< (n - 1);
		return (x + half) >>> n;
	endfunction

	function automatic wide_t clamp(input wide_t x, input wide_t lo, input wide_t hi);
		if (x > hi) begin
			return hi;
		end
		if (x < lo) begin
			return lo;
		end
		return x;
	endfunction

	// One axis of velocity Verlet: position uses the old velocity and old
	// acceleration, velocity uses the mean of old and new acceleration.
	function automatic void verlet_axis(
		inout logic signed [drvi_pkg::DATA_W-1:0] vel,
		inout logic signed [drvi_pkg::POS_W-1:0]  pos,
		input logic signed [drvi_pkg::DATA_W-1:0] a_old,
		input logic signed [drvi_pkg::DATA_W-1:0] a_new,
		input wide_t                              dt
	);
		wide_t a0;
		wide_t a1;
		wide_t v;
		wide_t p;
		wide_t v_mid;
		a0 = a_old;
		a1 = a_new;
		v = vel;
		p = pos;
		v_mid = clamp(v + round_shift(a0 * dt, FRAC_BITS + 1), Q31_MIN, Q31_MAX);
		p = clamp(p + round_shift(v_mid * dt, FRAC_BITS), POS_MIN, POS_MAX);
		v = clamp(v + round_shift((a0 + a1) * dt, FRAC_BITS + 1), Q31_MIN, Q31_MAX);
		vel = v[drvi_pkg::DATA_W-1:0];
		pos = p[drvi_pkg::POS_W-1:0];
	endfunction

	function automatic void reset_state();
		prev_accel_x = '0;
		prev_accel_y = '0;
		vel_x = '0;
		vel_y = '0;
		yaw = '0;
		pos_x = '0;
		pos_y = '0;
		prev_time_ms = '0;
	endfunction

	// Apply one item to the state and return the fix the block should report.
	function automatic drvi_pkg::result_t dead_reckon(input drvi_pkg::sample_t s);
		logic [drvi_pkg::TIME_W-1:0] span_ms;
		longint unsigned             ticks;
		wide_t                       dt;
		wide_t                       turn;
		wide_t                       heading;
		drvi_pkg::result_t           fix;
		unique case (s.func)
			drvi_pkg::FN_SAMPLE: begin
				span_ms = s.read_time_ms - prev_time_ms;
				ticks = ((64'(span_ms) << FRAC_BITS) + HALF_MSEC) / MSEC_PER_SEC;
				dt = (ticks > DT_CEILING) ? wide_t'(DT_CEILING) : wide_t'(ticks);
				verlet_axis(vel_x, pos_x, prev_accel_x, s.accel_x, dt);
				verlet_axis(vel_y, pos_y, prev_accel_y, s.accel_y, dt);
				// Yaw: turn in radians over the step, then converted to degrees.
				turn = s.gyro_z;
				turn = clamp(round_shift(turn * dt, FRAC_BITS), Q31_MIN, Q31_MAX);
				heading = yaw;
				heading = clamp(heading + round_shift(turn * RAD_TO_DEG, FRAC_BITS),
					Q31_MIN, Q31_MAX);
				yaw = heading[drvi_pkg::DATA_W-1:0];
				prev_accel_x = s.accel_x;
				prev_accel_y = s.accel_y;
				prev_time_ms = s.read_time_ms;
			end
			drvi_pkg::FN_CLR_POS: begin
				pos_x = '0;
				pos_y = '0;
			end
			drvi_pkg::FN_CLR_VEL: begin
				vel_x = '0;
				vel_y = '0;
			end
			drvi_pkg::FN_CLR_YAW: begin
				yaw = '0;
			end
			drvi_pkg::FN_CLR_ALL: begin
				pos_x = '0;
				pos_y = '0;
				vel_x = '0;
				vel_y = '0;
				yaw = '0;
			end
			default: begin
				// Unused codes leave everything as it is.
			end
		endcase
		fix.pos_x = pos_x;
		fix.pos_y = pos_y;
		fix.vel_x = vel_x;
		fix.vel_y = vel_y;
		fix.yaw_deg = yaw;
		return fix;
	endfunction

	function automatic void check_field(input string what, input longint want,
		input longint got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", what, want, got);
			mismatches++;
		end
	endfunction

	// Results are compared before new items are predicted, so a result can
	// never be matched against an item accepted at the same edge.
	always @(posedge clk) begin
		if (!arst_n) begin
			reset_state();
			expected_fixes.delete();
			mismatches = 0;
			checked = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_fixes.size() == 0) begin
					$error("result item arrived with no item outstanding");
					mismatches++;
				end else begin
					oldest = expected_fixes.pop_front();
					check_field("pos_x", oldest.pos_x, result.pos_x);
					check_field("pos_y", oldest.pos_y, result.pos_y);
					check_field("vel_x", oldest.vel_x, result.vel_x);
					check_field("vel_y", oldest.vel_y, result.vel_y);
					check_field("yaw_deg", oldest.yaw_deg, result.yaw_deg);
					checked++;
				end
			end
			if (sample_valid && !sample_stall) begin
				expected_fixes.push_back(dead_reckon(sample));
			end
		end
		pending = expected_fixes.size();
	end

endmodule

FILE: verif/dead_reckoning_verlet_integrator_test.sv
module dead_reckoning_verlet_integrator_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC_BITS    = 16;
	localparam int RESET_CYCLES = 11;
	localparam int HOLD_CYCLES  = 250;
	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 30;

	// Function codes the block does not define.
	localparam logic [drvi_pkg::FUNC_W-1:0] FUNC_UNUSED_FIRST = 3'd5;
	localparam logic [drvi_pkg::FUNC_W-1:0] FUNC_UNUSED_LAST  = 3'd7;

	// Q16.16 values used by the directed items.
	localparam logic signed [drvi_pkg::DATA_W-1:0] Q_ONE = 32'sd65536;
	localparam logic signed [drvi_pkg::DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [drvi_pkg::DATA_W-1:0] Q_MIN = 32'sh8000_0000;

	// Plausible motion: up to about 20 m/s^2 and 4 rad/s.
	localparam int ACCEL_SPAN = 20 * 65536;
	localparam int GYRO_SPAN  = 4 * 65536;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              sample_valid = 1'b0;
	logic              sample_stall;
	drvi_pkg::sample_t sample_item = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	drvi_pkg::result_t result_item;

	int          send_idle_pct = 27;
	int          recv_idle_pct = 60;
	bit          hold_request = 1'b0;
	logic [31:0] clock_ms = '0;
	int          quiet_cycles = 0;
	int          samples_sent = 0;
	int          clears_sent = 0;
	int          unused_sent = 0;
	int          mismatches;
	int          pending;
	int          checked;

	dead_reckoning_verlet_integrator #(
		.FRAC_BITS(FRAC_BITS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result_item)
	);

	dead_reckoning_checker #(
		.FRAC_BITS(FRAC_BITS)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result_item),
		.mismatches   (mismatches),
		.pending      (pending),
		.checked      (checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic drvi_pkg::sample_t make_item(
		input logic [drvi_pkg::FUNC_W-1:0] func,
		input logic [31:0] t_ms, input logic [31:0] ax, input logic [31:0] ay,
		input logic [31:0] gz);
		drvi_pkg::sample_t it;
		it.func = func;
		it.read_time_ms = t_ms;
		it.accel_x = ax;
		it.accel_y = ay;
		it.gyro_z = gz;
		return it;
	endfunction

	// Offer one item after a random gap and hold it until it is taken.
	task automatic send_item(input drvi_pkg::sample_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid = 1'b0;
			@(negedge clk);
		end
		sample_item = it;
		sample_valid = 1'b1;
		@(posedge clk);
		while (sample_stall) begin
			@(posedge clk);
		end
		@(negedge clk);
		if (it.func == drvi_pkg::FN_SAMPLE) begin
			samples_sent++;
		end else if (it.func <= drvi_pkg::FN_CLR_ALL) begin
			clears_sent++;
		end else begin
			unused_sent++;
		end
	endtask

	// Mostly a steady stream of plausible samples, mixed with clears, unused
	// codes, arbitrary samples and timestamps that step backwards.
	task automatic run_phase(input int send_pct, input int recv_pct, input int count);
		drvi_pkg::sample_t it;
		int                pick;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (count) begin
			pick = $urandom_range(99);
			it = make_item(drvi_pkg::FN_SAMPLE, $urandom, $urandom, $urandom, $urandom);
			if (pick < 72) begin
				clock_ms += $urandom_range(50);
				it.read_time_ms = clock_ms;
				it.accel_x = $urandom_range(2 * ACCEL_SPAN) - ACCEL_SPAN;
				it.accel_y = $urandom_range(2 * ACCEL_SPAN) - ACCEL_SPAN;
				it.gyro_z = $urandom_range(2 * GYRO_SPAN) - GYRO_SPAN;
			end else if (pick < 82) begin
				it.func = 3'($urandom_range(drvi_pkg::FN_CLR_POS, drvi_pkg::FN_CLR_ALL));
			end else if (pick < 86) begin
				it.func = 3'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST));
			end else if (pick < 94) begin
				clock_ms = it.read_time_ms;
			end else begin
				it.read_time_ms = clock_ms - $urandom_range(1, 2000);
				it.accel_x = $urandom_range(2 * ACCEL_SPAN) - ACCEL_SPAN;
				it.accel_y = $urandom_range(2 * ACCEL_SPAN) - ACCEL_SPAN;
				clock_ms = it.read_time_ms;
			end
			send_item(it);
		end
	endtask

	// Result side: random stalls, or one long hold-off when asked for.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_request) begin
				result_stall = 1'b1;
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
				end
				hold_request = 1'b0;
			end else begin
				result_stall = ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Watchdog: too long without any item moving on either channel.
	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		repeat (RESET_CYCLES) begin
			@(negedge clk);
		end
		arst_n = 1'b1;
		@(negedge clk);

		// The first sample measures dt from time zero.
		send_item(make_item(drvi_pkg::FN_SAMPLE, 32'd0, '0, '0, '0));
		send_item(make_item(drvi_pkg::FN_SAMPLE, 32'd40, Q_ONE, -Q_ONE, Q_ONE));
		send_item(make_item(drvi_pkg::FN_SAMPLE, 32'd1040, 2 * Q_ONE, Q_ONE, -Q_ONE));
		// Repeated timestamp gives a zero step with extreme inputs.
		send_item(make_item(drvi_pkg::FN_SAMPLE, 32'd1040, Q_MAX, Q_MIN, Q_MAX));
		send_item(make_item(drvi_pkg::FN_SAMPLE, 32'd1050, Q_MAX, Q_MIN, Q_MIN));
		// Timestamps going backwards wrap to a huge step and drive saturation.
		send_item(make_item(drvi_pkg::FN_SAMPLE, 32'd1049, Q_MAX, Q_MIN, Q_MAX));
		send_item(make_item(drvi_pkg::FN_SAMPLE, 32'd1048, Q_MAX, Q_MIN, Q_MAX));
		send_item(make_item(drvi_pkg::FN_SAMPLE, 32'd1047, Q_MAX, Q_MIN, Q_MAX));
		send_item(make_item(drvi_pkg::FN_CLR_VEL, 32'hFFFF_FFFF, Q_MIN, Q_MIN, Q_MIN));
		send_item(make_item(drvi_pkg::FN_SAMPLE, 32'd1046, Q_MIN, Q_MAX, Q_MIN));
		send_item(make_item(drvi_pkg::FN_SAMPLE, 32'd1045, Q_MIN, Q_MAX, Q_MIN));
		send_item(make_item(drvi_pkg::FN_SAMPLE, 32'd1044, Q_MIN, Q_MAX, Q_MIN));
		// Clears ignore the timestamp and acceleration fields.
		send_item(make_item(drvi_pkg::FN_CLR_POS, $urandom, $urandom, $urandom, $urandom));
		send_item(make_item(drvi_pkg::FN_CLR_YAW, $urandom, $urandom, $urandom, $urandom));
		for (int code = FUNC_UNUSED_FIRST; code <= FUNC_UNUSED_LAST; code++) begin
			send_item(make_item(3'(code), $urandom, $urandom, $urandom, $urandom));
		end
		send_item(make_item(drvi_pkg::FN_CLR_ALL, '1, '1, '1, '1));
		send_item(make_item(drvi_pkg::FN_SAMPLE, 32'hFFFF_FFFF, -Q_ONE, Q_ONE, Q_ONE));
		// Forward wrap through zero is a one-millisecond step.
		send_item(make_item(drvi_pkg::FN_SAMPLE, 32'd0, Q_ONE, -Q_ONE, -Q_ONE));
		send_item(make_item(drvi_pkg::FN_SAMPLE, 32'd16, -Q_ONE, Q_ONE, -Q_ONE));
		send_item(make_item(drvi_pkg::FN_CLR_ALL, '0, '0, '0, '0));
		clock_ms = 32'd16;

		run_phase(27, 60, 630);
		run_phase(60, 27, 630);
		// Hold results off while the sender keeps going, so the block backs up.
		hold_request = 1'b1;
		run_phase(0, 0, 640);
		sample_valid = 1'b0;

		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) begin
			@(negedge clk);
		end

		$display("Ran %0d samples, %0d clears and %0d unused codes; %0d results checked.",
			samples_sent, clears_sent, unused_sent, checked);
		$display("Included wrapped and backward timestamps, saturation and a long hold-off.");
		if (mismatches == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

FILE: dead_reckoning_verlet_integrator.f
src/drvi_pkg.sv
src/drvi_dt.sv
src/drvi_axis.sv
src/drvi_yaw.sv
src/dead_reckoning_verlet_integrator.sv
verif/dead_reckoning_checker.sv
verif/dead_reckoning_verlet_integrator_test.sv
